>>> sv/fab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_pkg
// Shared types and widths for the frame average background block.
// ----------------------------------------------------------------------------
package fab_pkg;

  localparam int MAX_PIXELS     = 65536;
  localparam int ADDR_W         = $clog2(MAX_PIXELS);
  localparam int IDX_W          = 16;
  localparam int PIX_W          = 8;
  localparam int SUM_W          = 32;
  localparam int FC_W           = 16;
  localparam int MEAN_W         = 8;
  localparam int MEAN_BIT_W     = $clog2(MEAN_W);
  localparam int REM_W          = FC_W + MEAN_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = MEAN_W / BITS_PER_STAGE;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ACCUM = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] sum;
    logic             in_range;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [REM_W-1:0]  rem;
    logic [MEAN_W-1:0] quo;
    logic              done;
  } div_t;

endpackage

>>> sv/fab_sum_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_sum_mem
// Per-pixel sum store with read-modify-write, write bypass and read issue.
// ----------------------------------------------------------------------------
module fab_sum_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_mode,
  input  logic [fab_pkg::IDX_W-1:0] in_pixel_index,
  input  logic [fab_pkg::PIX_W-1:0] in_pixel_value,
  output logic                      req_valid,
  input  logic                      req_ready,
  output fab_pkg::req_t             req
);
  import fab_pkg::*;

  logic [SUM_W-1:0] mem [MAX_PIXELS];

  logic             s1_v_r;
  logic [1:0]       s1_mode_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [PIX_W-1:0] s1_val_r;
  logic             s1_range_r;
  logic [SUM_W-1:0] rd_q_r;
  logic             fwd_hit_r;
  logic [SUM_W-1:0] fwd_data_r;

  logic             accept;
  logic             s1_read;
  logic             s1_fire;
  logic             wr_en;
  logic [SUM_W-1:0] wr_data;
  logic [SUM_W-1:0] cur_sum;

  assign cur_sum  = fwd_hit_r ? fwd_data_r : rd_q_r;
  assign s1_read  = (s1_mode_r == MODE_READ);
  assign s1_fire  = s1_v_r && (!s1_read || req_ready);
  assign in_ready = !s1_v_r || s1_fire;
  assign accept   = in_valid && in_ready;
  assign wr_en    = s1_fire && s1_range_r &&
                    (s1_mode_r == MODE_CLEAR || s1_mode_r == MODE_ACCUM);
  assign wr_data  = (s1_mode_r == MODE_CLEAR) ? '0 : cur_sum + SUM_W'(s1_val_r);

  assign req_valid    = s1_v_r && s1_read;
  assign req.idx      = s1_idx_r;
  assign req.sum      = cur_sum;
  assign req.in_range = s1_range_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q_r <= mem[in_pixel_index[ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem[s1_idx_r[ADDR_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (accept) begin
        fwd_hit_r <= wr_en && (s1_idx_r == in_pixel_index);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r  <= in_mode;
      s1_idx_r   <= in_pixel_index;
      s1_val_r   <= in_pixel_value;
      s1_range_r <= (32'(in_pixel_index) < 32'(MAX_PIXELS));
      fwd_data_r <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ready)
    else $error("sum stage empty but input not ready");

  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_hit_r) |-> $past(wr_en))
    else $error("bypass set without a write");

  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && !req_ready |=> s1_v_r && $stable(s1_idx_r) && $stable(s1_mode_r))
    else $error("stalled read request lost");
`endif

endmodule

>>> sv/fab_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_div
// Pipelined saturating divider: mean = min(sum / frame_count, 255).
// ----------------------------------------------------------------------------
module fab_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fab_pkg::FC_W-1:0]   frame_count,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  fab_pkg::req_t              req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fab_pkg::MEAN_W-1:0] out_mean_value,
  output logic [fab_pkg::IDX_W-1:0]  out_index
);
  import fab_pkg::*;

  logic v_r   [DIV_STAGES+1];
  div_t st_r  [DIV_STAGES+1];
  div_t st_nxt[DIV_STAGES+1];
  logic rdy   [DIV_STAGES+2];

  assign rdy[DIV_STAGES+1] = out_ready;
  assign req_ready         = rdy[0];

  always_comb begin : pre_c
    logic sat;
    sat = (req.sum[SUM_W-1:MEAN_W] >= (SUM_W-MEAN_W)'(frame_count));
    st_nxt[0].idx  = req.idx;
    st_nxt[0].rem  = req.sum[REM_W-1:0];
    st_nxt[0].quo  = (req.in_range && sat) ? '1 : '0;
    st_nxt[0].done = !req.in_range || sat;
  end

  genvar k;
  generate
    for (k = 0; k <= DIV_STAGES; k++) begin : g_stage
      assign rdy[k] = !v_r[k] || rdy[k+1];

      if (k > 0) begin : g_step
        always_comb begin : step_c
          div_t                  d;
          logic [MEAN_BIT_W-1:0] sh;
          logic [REM_W-1:0]      trial;
          d = st_r[k-1];
          for (int b = 0; b < BITS_PER_STAGE; b++) begin
            sh    = MEAN_BIT_W'(MEAN_W - 1 - BITS_PER_STAGE * (k - 1) - b);
            trial = REM_W'(frame_count) << sh;
            if (!d.done && d.rem >= trial) begin
              d.rem     = d.rem - trial;
              d.quo[sh] = 1'b1;
            end
          end
          st_nxt[k] = d;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= (k == 0) ? req_valid : v_r[(k == 0) ? 0 : k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          st_r[k] <= st_nxt[k];
        end
      end
    end
  endgenerate

  assign out_valid      = v_r[DIV_STAGES];
  assign out_mean_value = st_r[DIV_STAGES].quo;
  assign out_index      = st_r[DIV_STAGES].idx;

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DIV_STAGES] && !out_ready |=> v_r[DIV_STAGES])
    else $error("stalled result dropped");

  a_done_quo: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DIV_STAGES] && st_r[DIV_STAGES].done |->
      (st_r[DIV_STAGES].quo == '0 || st_r[DIV_STAGES].quo == '1))
    else $error("early-out quotient neither zero nor saturated");

  a_head_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> req_ready)
    else $error("empty divider head not ready");
`endif

endmodule

>>> sv/frame_average_background.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_average_background
// Per-pixel running sums and their saturated mean as a background image.
// ----------------------------------------------------------------------------
// channel  | ports                                        | direction
// input    | in_valid/in_ready, in_mode, in_pixel_index,  | in
//          | in_pixel_value                               |
// result   | out_valid/out_ready, out_mean_value,         | out
//          | out_index                                    |
// config   | cfg_we, cfg_wdata (frame_count)              | in
//
// One transaction per cycle unless out_ready backpressure stalls a read; a
// read is loaded into the sum read register at acceptance, then passes five
// divider stages before out_valid rises. The sum memory does one read and
// one write per cycle, with write bypass.
// Reset clears the pipeline valids and sets frame_count to 1; sums are not
// cleared. A stalled result holds its stage and backpressure fills bubbles
// upstream before in_ready drops.
// ----------------------------------------------------------------------------
module frame_average_background (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic [fab_pkg::IDX_W-1:0]  in_pixel_index,
  input  logic [fab_pkg::PIX_W-1:0]  in_pixel_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fab_pkg::MEAN_W-1:0] out_mean_value,
  output logic [fab_pkg::IDX_W-1:0]  out_index,
  input  logic                       cfg_we,
  input  logic [fab_pkg::FC_W-1:0]   cfg_wdata
);
  import fab_pkg::*;

  logic [FC_W-1:0] frame_count_r;
  logic            req_valid;
  logic            req_ready;
  req_t            req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FC_W'(1);
    end else if (cfg_we) begin
      frame_count_r <= cfg_wdata;
    end
  end

  fab_sum_mem u_sum (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_pixel_index (in_pixel_index),
    .in_pixel_value (in_pixel_value),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req)
  );

  fab_div u_div (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_count    (frame_count_r),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mean_value (out_mean_value),
    .out_index      (out_index)
  );

endmodule
